// File: sv/hcld_pkg.sv
// ----------------------------------------------------------------------------
// hcld_pkg
// shared types and constants of the hsv color line detector
// ----------------------------------------------------------------------------
package hcld_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned CoordW   = 10;
  localparam int unsigned PixProdW = 11;

  localparam logic [CfgIdxW-1:0] CfgHueMin  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgHueMax  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSatMin  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRunThr  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRowsThr = 3'd4;

  localparam logic [7:0] HueMinRst  = 8'd100;
  localparam logic [7:0] HueMaxRst  = 8'd115;
  localparam logic [7:0] SatMinRst  = 8'd100;
  localparam logic [7:0] RunThrRst  = 8'd10;
  localparam logic [6:0] RowsThrRst = 7'd3;

  localparam logic [7:0]          WrapLimit = 8'd160;
  localparam logic [CoordW-1:0]   CoordMax  = 10'd1023;
  localparam logic [7:0]          RunMax    = 8'd255;
  localparam logic [6:0]          HitRowsMax = 7'd127;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic       row_end;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic              detected;
    logic [CoordW-1:0] hit_x;
    logic [CoordW-1:0] hit_y;
  } out_item_t;

  typedef struct packed {
    logic [7:0] hue_min;
    logic [7:0] hue_max;
    logic [7:0] sat_min;
    logic [7:0] run_threshold;
    logic [6:0] rows_threshold;
  } cfg_t;

endpackage

// File: sv/hcld_match.sv
// ----------------------------------------------------------------------------
// hcld_match
// color window test of one pixel against hue and saturation bounds
// ----------------------------------------------------------------------------
module hcld_match import hcld_pkg::*; (
  input  logic [7:0] hue_i,
  input  logic [7:0] sat_i,
  input  cfg_t       cfg_i,
  output logic       match_o
);

  logic wrap;
  logic hue_ok;

  always_comb begin
    wrap = cfg_i.hue_max > WrapLimit;
    if (wrap) begin
      hue_ok = (hue_i < cfg_i.hue_min) || (hue_i > cfg_i.hue_max);
    end else begin
      hue_ok = (hue_i > cfg_i.hue_min) && (hue_i < cfg_i.hue_max);
    end
    match_o = hue_ok && (sat_i > cfg_i.sat_min);
  end

endmodule

// File: sv/hcld_track.sv
// ----------------------------------------------------------------------------
// hcld_track
// run and row tracking state with the frame result register
// ----------------------------------------------------------------------------
module hcld_track import hcld_pkg::*; #(
  parameter int unsigned SAMPLE_STEP = 8,
  parameter int unsigned MAX_COLS    = 128,
  parameter int unsigned MAX_ROWS    = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  logic      match_i,
  input  logic      row_end_i,
  input  logic      frame_end_i,
  input  cfg_t      cfg_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [ColW-1:0] ColLast = ColW'(MAX_COLS - 1);
  localparam logic [RowW-1:0] RowLast = RowW'(MAX_ROWS - 1);

  function automatic logic [CoordW-1:0] to_pixel(input logic [PixProdW-1:0] idx);
    logic [PixProdW-1:0] prod;
    prod = idx * PixProdW'(SAMPLE_STEP);
    if (prod > PixProdW'(CoordMax)) begin
      return CoordMax;
    end
    return prod[CoordW-1:0];
  endfunction

  logic [7:0]        run_q, run_d;
  logic              row_hit_q, row_hit_d;
  logic [6:0]        hit_rows_q, hit_rows_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [CoordW-1:0] last_x_q, last_x_d;
  logic [CoordW-1:0] last_y_q, last_y_d;
  logic              det_q, det_d;
  logic              out_v_q, out_v_d;
  out_item_t         out_q, out_d;
  logic              adv;
  logic              row_end;

  assign ready_o = !out_v_q || out_ready_i;
  assign adv     = valid_i && ready_o;
  assign row_end = row_end_i || frame_end_i;

  always_comb begin
    run_d      = run_q;
    row_hit_d  = row_hit_q;
    hit_rows_d = hit_rows_q;
    col_d      = col_q;
    row_d      = row_q;
    last_x_d   = last_x_q;
    last_y_d   = last_y_q;
    det_d      = det_q;
    out_d      = out_q;
    out_v_d    = out_v_q && !out_ready_i;
    if (adv) begin
      if (match_i) begin
        run_d = (run_q < RunMax) ? run_q + 8'd1 : RunMax;
      end else begin
        run_d = '0;
      end
      if (run_d >= cfg_i.run_threshold) begin
        last_x_d  = to_pixel(PixProdW'(col_q));
        row_hit_d = 1'b1;
      end
      if (col_q < ColLast) begin
        col_d = col_q + ColW'(1);
      end
      if (row_end) begin
        if (row_hit_d) begin
          hit_rows_d = (hit_rows_q < HitRowsMax) ? hit_rows_q + 7'd1 : HitRowsMax;
        end else begin
          hit_rows_d = '0;
        end
        if (hit_rows_d >= cfg_i.rows_threshold) begin
          last_y_d = to_pixel(PixProdW'(row_q));
          det_d    = 1'b1;
        end
        if (row_q < RowLast) begin
          row_d = row_q + RowW'(1);
        end
        col_d     = '0;
        run_d     = '0;
        row_hit_d = 1'b0;
      end
      if (frame_end_i) begin
        out_d.detected = det_d;
        out_d.hit_x    = last_x_d;
        out_d.hit_y    = last_y_d;
        out_v_d        = 1'b1;
        run_d      = '0;
        row_hit_d  = 1'b0;
        hit_rows_d = '0;
        col_d      = '0;
        row_d      = '0;
        last_x_d   = '0;
        last_y_d   = '0;
        det_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= '0;
      row_hit_q  <= 1'b0;
      hit_rows_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
      last_x_q   <= '0;
      last_y_q   <= '0;
      det_q      <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      run_q      <= run_d;
      row_hit_q  <= row_hit_d;
      hit_rows_q <= hit_rows_d;
      col_q      <= col_d;
      row_q      <= row_d;
      last_x_q   <= last_x_d;
      last_y_q   <= last_y_d;
      det_q      <= det_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/hsv_color_line_detector_top.sv
// ----------------------------------------------------------------------------
// hsv_color_line_detector_top
// finds a horizontal line of a chosen color in a stream of subsampled pixels
// ----------------------------------------------------------------------------
// usage
//   in channel: one hsv pixel per request with row_end and frame_end marks
//   out channel: one request per frame, sent for the pixel that has frame_end
//   cfg port: plain write of hue window, saturation floor and thresholds
// throughput and pipeline
//   one pixel per cycle while no result waits on out_ready_i; a pixel
//   is held in an input register, then the color test and counter update
//   run combinationally into the tracking state and the result register,
//   which holds the result of a frame_end pixel until out_ready_i takes it
// reset
//   thresholds return to their defaults, all row and frame state clears,
//   no result is pending
// stall
//   while a result waits on out_ready_i the input register holds one more
//   pixel; in_ready_o drops only if that register is full as well
// ----------------------------------------------------------------------------
module hsv_color_line_detector_top import hcld_pkg::*; #(
  parameter int unsigned SAMPLE_STEP = 8,
  parameter int unsigned MAX_COLS    = 128,
  parameter int unsigned MAX_ROWS    = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t     cfg_q, cfg_d;
  in_item_t px_q;
  logic     px_v_q, px_v_d;
  logic     trk_ready;
  logic     match;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHueMin:  cfg_d.hue_min        = cfg_wdata_i;
        CfgHueMax:  cfg_d.hue_max        = cfg_wdata_i;
        CfgSatMin:  cfg_d.sat_min        = cfg_wdata_i;
        CfgRunThr:  cfg_d.run_threshold  = cfg_wdata_i;
        CfgRowsThr: cfg_d.rows_threshold = cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_min        <= HueMinRst;
      cfg_q.hue_max        <= HueMaxRst;
      cfg_q.sat_min        <= SatMinRst;
      cfg_q.run_threshold  <= RunThrRst;
      cfg_q.rows_threshold <= RowsThrRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input register
  assign in_ready_o = !px_v_q || trk_ready;
  assign px_v_d     = in_valid_i || (px_v_q && !trk_ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_v_q <= 1'b0;
    end else if (in_ready_o) begin
      px_v_q <= px_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      px_q <= in_data_i;
    end
  end

  hcld_match u_match (
    .hue_i   (px_q.hue),
    .sat_i   (px_q.sat),
    .cfg_i   (cfg_q),
    .match_o (match)
  );

  hcld_track #(
    .SAMPLE_STEP (SAMPLE_STEP),
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (px_v_q),
    .ready_o     (trk_ready),
    .match_i     (match),
    .row_end_i   (px_q.row_end),
    .frame_end_i (px_q.frame_end),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sv/hcld_checker.sv
// ----------------------------------------------------------------------------
// hcld_checker
// port level checks of the hsv color line detector
// ----------------------------------------------------------------------------
module hcld_checker import hcld_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input out_item_t           out_data_o
);

  // input only backs up behind a stalled result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a stalled result");

  // a taken result frees the input side
  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |-> in_ready_o)
    else $error("input not ready while result drains");

  // no result without earlier pixel traffic
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i, 2) || $past(!in_ready_o, 2) ||
      $past(in_valid_i, 3) || $past(out_valid_o, 1))
    else $error("result without a pixel");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind hsv_color_line_detector_top hcld_checker u_hcld_checker (.*);
